/* hw/rtl/dtw_pkg.sv */
// Shared types, constants and calendar tables for the date to weekday block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtw_pkg;

  // Request payloads
  typedef struct packed {
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
  } dtw_in_t;

  typedef struct packed {
    logic [2:0] weekday;
    logic [8:0] ordinal_day;
    logic       leap_flag;
  } dtw_out_t;

  // Year split into century key, low two decimal digits and leap flag
  typedef struct packed {
    logic [1:0] cent;
    logic [6:0] low2;
    logic       leap;
  } dtw_year_t;

  localparam logic [11:0] DefaultYear = 12'd2008;
  localparam logic [3:0]  FirstMonth  = 4'd1;
  localparam logic [3:0]  LastMonth   = 4'd12;
  localparam logic [3:0]  MarchMonth  = 4'd3;
  localparam logic [4:0]  FirstDay    = 5'd1;

  // floor(y / 100) = (y * 5243) >> 19, exact for y < 43699
  localparam int          HundredShift = 19;
  localparam logic [12:0] HundredRecip = 13'd5243;
  localparam int          ProdW        = 25;

  // floor(s / 7) = (s * 147) >> 10, exact for s < 205
  localparam int         SevenShift = 10;
  localparam logic [7:0] SevenRecip = 8'd147;

  // Weekday month key, leap January and February take their own keys
  function automatic logic [2:0] month_key(input logic [3:0] m, input logic leap);
    logic [2:0] k;
    case (m)
      4'd1:    k = leap ? 3'd6 : 3'd0;
      4'd2:    k = leap ? 3'd2 : 3'd3;
      4'd3:    k = 3'd3;
      4'd4:    k = 3'd6;
      4'd5:    k = 3'd1;
      4'd6:    k = 3'd4;
      4'd7:    k = 3'd6;
      4'd8:    k = 3'd2;
      4'd9:    k = 3'd5;
      4'd10:   k = 3'd0;
      4'd11:   k = 3'd3;
      4'd12:   k = 3'd5;
      default: k = 3'd0;
    endcase
    return k;
  endfunction

  // Days before the first of the month in a common year;
  // equals floor(30.6*(m+1)) - 122 + 59 from March on
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/date_to_weekday_and_ordinal.sv */
// Top level of the Gregorian date to weekday / ordinal day converter.
// Depends on dtw_pkg and dtw_year_split.
`timescale 1ns / 1ps
`default_nettype none

// Converts one calendar date request (year, month, day) into the day of the
// week (Sunday = 0), the day of the year (January 1 = 1) and the Gregorian
// leap flag. Year 0 is taken as 2008, months 0 and 13..15 as January, day 0
// as the first; days past the end of a month are not checked and simply run
// on. The block is a four-stage pipeline: one request is accepted per clock
// while the output side does not stall. The stages are: input clean-up and
// the y*5243 reciprocal multiply (divide by 100), year split plus month
// tables and weekday partial sum, a reciprocal multiply for the divide by 7,
// and the final mod-7 subtract into the output register. Each stage holds
// while the one after it is full and stalled, so backpressure loses or
// repeats nothing. There is no configuration and no state beyond the
// pipeline registers.

module date_to_weekday_and_ordinal (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dtw_pkg::dtw_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dtw_pkg::dtw_out_t out_data_o
);
  import dtw_pkg::*;

  // stage 1: cleaned date and divide-by-100 product
  logic              v1_q;
  logic [11:0]       y1_q;
  logic [3:0]        m1_q;
  logic [4:0]        d1_q;
  logic [ProdW-1:0]  prod1_q;
  logic [11:0]       y1_d;
  logic [3:0]        m1_d;
  logic [4:0]        d1_d;

  // stage 2: weekday sum, ordinal day, leap
  logic              v2_q;
  logic [7:0]        sum2_q, sum2_d;
  logic [8:0]        ord2_q, ord2_d;
  logic              leap2_q;
  dtw_year_t         split;

  // stage 3: sum and its quotient by 7
  logic              v3_q;
  logic [7:0]        sum3_q;
  logic [4:0]        quo3_q;
  logic [15:0]       quo_prod;
  logic [8:0]        ord3_q;
  logic              leap3_q;

  // stage 4: output register
  logic              v4_q;
  dtw_out_t          out_q, out_d;

  logic rdy1, rdy2, rdy3, rdy4;

  // a stage moves when it is empty or the next one moves
  assign rdy4       = !v4_q || !out_stall_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  // input clean-up
  always_comb begin
    y1_d = (in_data_i.year_in == 12'd0) ? DefaultYear : in_data_i.year_in;
    m1_d = (in_data_i.month_in < FirstMonth || in_data_i.month_in > LastMonth)
           ? FirstMonth : in_data_i.month_in;
    d1_d = (in_data_i.day_in == 5'd0) ? FirstDay : in_data_i.day_in;
  end

  dtw_year_split u_year_split (
    .year_i  (y1_q),
    .prod_i  (prod1_q),
    .split_o (split)
  );

  // weekday partial sum: 2*(3-cent) + yb2 + yb2/4 + key + day, at most 166
  always_comb begin
    sum2_d = 8'({~split.cent, 1'b0}) + 8'(split.low2) + 8'(split.low2 >> 2)
           + 8'(month_key(m1_q, split.leap)) + 8'(d1_q);
    ord2_d = days_before(m1_q) + 9'(d1_q)
           + 9'(split.leap && (m1_q >= MarchMonth));
  end

  assign quo_prod = 16'(sum2_q) * 16'(SevenRecip);

  always_comb begin
    out_d.weekday     = 3'(sum3_q - 8'({3'd0, quo3_q} * 8'd7));
    out_d.ordinal_day = ord3_q;
    out_d.leap_flag   = leap3_q;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      y1_q    <= y1_d;
      m1_q    <= m1_d;
      d1_q    <= d1_d;
      prod1_q <= ProdW'(y1_d) * ProdW'(HundredRecip);
    end
    if (rdy2 && v1_q) begin
      sum2_q  <= sum2_d;
      ord2_q  <= ord2_d;
      leap2_q <= split.leap;
    end
    if (rdy3 && v2_q) begin
      sum3_q  <= sum2_q;
      quo3_q  <= quo_prod[SevenShift +: 5];
      ord3_q  <= ord2_q;
      leap3_q <= leap2_q;
    end
    if (rdy4 && v3_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* hw/rtl/dtw_year_split.sv */
// Year decomposition: century key, low two digits and Gregorian leap flag.
// Depends on dtw_pkg; takes the registered y * HundredRecip product.
`timescale 1ns / 1ps
`default_nettype none

module dtw_year_split (
  input  logic [11:0]               year_i,
  input  logic [dtw_pkg::ProdW-1:0] prod_i,
  output dtw_pkg::dtw_year_t        split_o
);
  import dtw_pkg::*;

  logic [5:0]  hundreds;
  logic [11:0] hund_part;
  logic [6:0]  low2;

  assign hundreds  = prod_i[ProdW-1:HundredShift];
  assign hund_part = 12'({6'd0, hundreds} * 12'd100);
  assign low2      = 7'(year_i - hund_part);

  assign split_o.cent = hundreds[1:0];
  assign split_o.low2 = low2;
  // century years leap only when divisible by 400
  assign split_o.leap = (low2 == 7'd0) ? (hundreds[1:0] == 2'd0)
                                       : (year_i[1:0] == 2'd0);

endmodule

`default_nettype wire
